// ===== design/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg
// Shared widths, operation and status codes, register map for the
// chained hash set engine.
// ----------------------------------------------------------------------------
package chs_pkg;

  // Field widths
  localparam int KEY_W    = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int BIDX_W   = 4;
  localparam int RCNT_W   = 4;
  localparam int BCNT_W   = 5;

  // Default geometry
  localparam int NUM_BUCKETS_DEF  = 16;
  localparam int BUCKET_DEPTH_DEF = 8;

  // Register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_BUCKET_COUNT = 1'b0;
  localparam logic REG_SET_MODE     = 1'b1;
  localparam logic [BCNT_W-1:0] BUCKET_COUNT_RST = 5'd16;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

endpackage

// ===== design/chs_req_if.sv =====
// ----------------------------------------------------------------------------
// chs_req_if
// Request channel: operation code and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface chs_req_if
  import chs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

// ===== design/chs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// chs_rsp_if
// Response channel: status, bucket and removed count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface chs_rsp_if
  import chs_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BIDX_W-1:0]   bucket_index;
  logic [RCNT_W-1:0]   removed_count;

  modport source (output valid, output status, output bucket_index, output removed_count,
                  input ready);
  modport sink   (input valid, input status, input bucket_index, input removed_count,
                  output ready);
endinterface

// ===== design/chs_ram.sv =====
// ----------------------------------------------------------------------------
// chs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chs_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/chained_hash_set_engine.sv =====
// ----------------------------------------------------------------------------
// chained_hash_set_engine
// Hash set of 32-bit keys, bucket = key mod bucket_count, fixed slots/bucket.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : request (func, key). Taken when valid & ready.
//   out_rsp : one response per request (status, bucket_index, removed_count).
//   APB     : reg 0 bucket_count at 0x0, reg 1 set_mode at 0x4. Write only
//             while the engine is idle.
// Steps per request:
//   restoring division (one quotient bit per cycle) for the hash, then
//   streaming the bucket's slots through the registered-read slot RAM, a
//   finish state (add write-back) and a hand-off into the output register.
//   A new request is taken only once the previous one has been handed off
//   and the engine is back in idle.
// Stall: the response waits in the output register; the next request is
//   accepted and processed meanwhile and parks in the hand-off state until
//   the output register frees up.
// Reset: synchronous, active low. After reset a clearing pass writes every
//   slot empty, during which in_req.ready stays low. Config writes are
//   taken throughout.
// ----------------------------------------------------------------------------
module chained_hash_set_engine
  import chs_pkg::*;
#(
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  chs_req_if.sink               in_req,
  chs_rsp_if.source             out_rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int TOTAL  = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SLOT_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int CNT_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int WORD_W = KEY_W + 1;   // {valid, key}
  localparam int DCNT_W = $clog2(KEY_W);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Config registers
  logic [BCNT_W-1:0] bcnt_r;
  logic              set_mode_r;

  // Request context
  logic [FUNC_W-1:0] func_r;
  logic [KEY_W-1:0]  key_r;

  // Divider
  logic [BCNT_W-1:0] div_r;
  logic [BCNT_W-1:0] rem_r;
  logic [BCNT_W-1:0] rem_step;
  logic [BCNT_W:0]   trial;
  logic [DCNT_W-1:0] div_cnt_r;
  logic [BCNT_W-1:0] div_eff;

  // Scan
  logic [ADDR_W-1:0] base_r;
  logic [CNT_W-1:0]  issue_r;
  logic              chk_vld_r;
  logic [SLOT_W-1:0] chk_slot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              free_fnd_r;
  logic [SLOT_W-1:0] free_slot_r;
  logic              scan_done;
  logic              rd_match;

  // Result hand-off and output register
  logic [STATUS_W-1:0] res_status_r;
  logic [BIDX_W-1:0]   res_bidx_r;
  logic [RCNT_W-1:0]   res_rcnt_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [BIDX_W-1:0]   out_bidx_r;
  logic [RCNT_W-1:0]   out_rcnt_r;
  logic                out_load;

  // Clearing pass
  logic [ADDR_W-1:0] clr_r;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic in_acc;
  logic cfg_wr;
  logic add_dup;
  logic add_wr;

  // --------------------------------------------------------------------------
  // APB register file
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r     <= BUCKET_COUNT_RST;
      set_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BUCKET_COUNT: bcnt_r     <= pwdata[BCNT_W-1:0];
        REG_SET_MODE:     set_mode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BUCKET_COUNT: prdata = {{(APB_DATA_W-BCNT_W){1'b0}}, bcnt_r};
      REG_SET_MODE:     prdata = {{(APB_DATA_W-1){1'b0}}, set_mode_r};
      default:          prdata = '0;
    endcase
  end

  // Divisor saturated to [1, NUM_BUCKETS]
  always_comb begin
    div_eff = bcnt_r;
    if (bcnt_r == '0) begin
      div_eff = BCNT_W'(1);
    end else if (32'(bcnt_r) > NUM_BUCKETS) begin
      div_eff = BCNT_W'(NUM_BUCKETS);
    end
  end

  // --------------------------------------------------------------------------
  // Restoring division step: remainder only, MSB first
  // --------------------------------------------------------------------------
  assign trial = {rem_r, key_r[div_cnt_r]};

  always_comb begin
    if (trial >= {1'b0, div_r}) begin
      rem_step = BCNT_W'(trial - {1'b0, div_r});
    end else begin
      rem_step = trial[BCNT_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Slot RAM: {valid, key} per slot
  // --------------------------------------------------------------------------
  chs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TOTAL)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_re    = (state_r == ST_SCAN) && (issue_r < CNT_W'(BUCKET_DEPTH));
  assign ram_raddr = base_r + ADDR_W'(issue_r[SLOT_W-1:0]);
  assign rd_match  = ram_rdata[KEY_W] && (ram_rdata[KEY_W-1:0] == key_r);
  assign scan_done = (issue_r == CNT_W'(BUCKET_DEPTH)) && !chk_vld_r;

  assign add_dup = set_mode_r && (cnt_r != '0);
  assign add_wr  = (state_r == ST_FIN) && (func_r == FUNC_ADD) && !add_dup && free_fnd_r;

  // Only one writer per state; a remove clears slot k while slot k+1 is read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if ((state_r == ST_SCAN) && chk_vld_r && rd_match && (func_r == FUNC_REMOVE)) begin
      ram_we    = 1'b1;
      ram_waddr = base_r + ADDR_W'(chk_slot_r);
    end else if (add_wr) begin
      ram_we    = 1'b1;
      ram_waddr = base_r + ADDR_W'(free_slot_r);
      ram_wdata = {1'b1, key_r};
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_req.ready = (state_r == ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign out_load     = (state_r == ST_RESP) && (!out_valid_r || out_rsp.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == ADDR_W'(TOTAL - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = ST_DIV;
      ST_DIV:   if (div_cnt_r == '0) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_done) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_RESP;
      ST_RESP:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= ram_re;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r     <= in_req.func;
      key_r      <= in_req.key;
      div_r      <= div_eff;
      rem_r      <= '0;
      div_cnt_r  <= DCNT_W'(KEY_W - 1);
      issue_r    <= '0;
      cnt_r      <= '0;
      free_fnd_r <= 1'b0;
    end
    if (state_r == ST_DIV) begin
      rem_r     <= rem_step;
      div_cnt_r <= div_cnt_r - DCNT_W'(1);
      if (div_cnt_r == '0) begin
        base_r <= ADDR_W'(32'(rem_step) * BUCKET_DEPTH);
      end
    end
    if (ram_re) begin
      issue_r <= issue_r + CNT_W'(1);
    end
    chk_slot_r <= issue_r[SLOT_W-1:0];
    if ((state_r == ST_SCAN) && chk_vld_r) begin
      if (rd_match) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (!ram_rdata[KEY_W] && !free_fnd_r) begin
        free_fnd_r  <= 1'b1;
        free_slot_r <= chk_slot_r;
      end
    end
    if (state_r == ST_FIN) begin
      res_bidx_r <= rem_r[BIDX_W-1:0];
      res_rcnt_r <= '0;
      unique case (func_r)
        FUNC_ADD: begin
          if (add_dup) begin
            res_status_r <= STAT_DUPLICATE;
          end else if (free_fnd_r) begin
            res_status_r <= STAT_DONE;
          end else begin
            res_status_r <= STAT_FULL;
          end
        end
        FUNC_REMOVE: begin
          res_status_r <= (cnt_r != '0) ? STAT_DONE : STAT_NOT_FOUND;
          res_rcnt_r   <= RCNT_W'(cnt_r);
        end
        FUNC_CONTAINS: begin
          res_status_r <= (cnt_r != '0) ? STAT_FOUND : STAT_NOT_FOUND;
        end
        default: begin
          res_status_r <= STAT_DONE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_bidx_r   <= res_bidx_r;
      out_rcnt_r   <= res_rcnt_r;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.bucket_index  = out_bidx_r;
  assign out_rsp.removed_count = out_rcnt_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // During the scan, only a remove may write the slot RAM
  a_scan_wr_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r == ST_SCAN)) |-> (func_r == FUNC_REMOVE))
    else $error("slot write during scan by non-remove");

  // Hash remainder is below the divisor once division ends
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rem_r < div_r))
    else $error("remainder not below divisor");

  // Finish only after the read pipeline has drained
  a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (!chk_vld_r && (issue_r == CNT_W'(BUCKET_DEPTH))))
    else $error("finish with slot reads outstanding");

  // Match count never exceeds the bucket depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (32'(cnt_r) <= BUCKET_DEPTH))
    else $error("match count above bucket depth");

  // A hand-off into the output register is never dropped
  a_load_lands: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("response hand-off lost");

endmodule

// ===== sim/tb_chained_hash_set_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chained_hash_set_engine
// Self-checking bench for the chained hash set engine. A clocked driver feeds
// add/remove/contains requests from a pending queue, and a golden table model
// predicts each response at acceptance. A clocked monitor checks every
// response field against the oldest prediction. Phases sweep bucket count and
// set mode over their extremes and vary sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_chained_hash_set_engine;
  import chs_pkg::*;

  localparam int NB      = NUM_BUCKETS_DEF;
  localparam int DEPTH   = BUCKET_DEPTH_DEF;
  localparam int SLOTS   = NB * DEPTH;
  // per-request latency of the engine
  localparam int LATENCY = DEPTH + 36;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 64;

  // func 3 has no name in the package; it is a defined no-op
  localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BIDX_W-1:0]   bucket_index;
    logic [RCNT_W-1:0]   removed_count;
  } rsp_t;

  logic clk;
  logic rst_n;

  // APB config port
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  chs_req_if in_req ();
  chs_rsp_if out_rsp ();

  chained_hash_set_engine DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Golden table: keys, valid bits and the two config registers
  // --------------------------------------------------------------------------
  logic [KEY_W-1:0]  tbl_key   [SLOTS];
  logic              tbl_valid [SLOTS];
  logic [BCNT_W-1:0] mdl_bucket_count;
  logic              mdl_set_mode;

  req_t pending_req  [$];  // requests waiting for the driver
  rsp_t expected_rsp [$];  // predicted responses, oldest first
  logic [KEY_W-1:0] key_pool [$];

  int src_idle_pct;
  int sink_stall_pct;
  int n_errors;
  int n_accepted;
  int n_checked;
  int n_settings;
  int stat_seen [5];

  // Apply one request to the golden table and return its response.
  function automatic rsp_t apply_request(req_t r);
    int unsigned divisor;
    int unsigned bkt;
    int unsigned base;
    int unsigned hits;
    int unsigned freed;
    int s;
    bit placed;
    rsp_t res;
    // divisor saturates: 0 acts as 1, above NB acts as NB
    if (mdl_bucket_count == 0) divisor = 1;
    else if (mdl_bucket_count > NB) divisor = NB;
    else divisor = mdl_bucket_count;
    bkt = r.key % divisor;
    base = bkt * DEPTH;
    hits = 0;
    freed = 0;
    placed = 1'b0;
    for (s = 0; s < DEPTH; s++) begin
      if (tbl_valid[base+s] && tbl_key[base+s] == r.key) hits++;
    end
    res.status = STAT_DONE;
    case (r.func)
      FUNC_ADD: begin
        if (mdl_set_mode && hits != 0) begin
          res.status = STAT_DUPLICATE;
        end else begin
          res.status = STAT_FULL;
          // lowest free slot wins
          for (s = 0; s < DEPTH; s++) begin
            if (!placed && !tbl_valid[base+s]) begin
              tbl_key[base+s] = r.key;
              tbl_valid[base+s] = 1'b1;
              placed = 1'b1;
              res.status = STAT_DONE;
            end
          end
        end
      end
      FUNC_REMOVE: begin
        // every copy goes
        for (s = 0; s < DEPTH; s++) begin
          if (tbl_valid[base+s] && tbl_key[base+s] == r.key) begin
            tbl_valid[base+s] = 1'b0;
            freed++;
          end
        end
        res.status = (freed != 0) ? STAT_DONE : STAT_NOT_FOUND;
      end
      FUNC_CONTAINS: begin
        res.status = (hits != 0) ? STAT_FOUND : STAT_NOT_FOUND;
      end
      default: ;
    endcase
    res.bucket_index = BIDX_W'(bkt);
    res.removed_count = RCNT_W'(freed);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  // --------------------------------------------------------------------------
  // Clock, limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: the limit lies well above the slowest legal run.
  initial begin
    #8_000_000;
    $display("FAIL chained_hash_set_engine");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: takes requests from pending_req, predicts on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    req_t acc;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        acc.func = in_req.func;
        acc.key = in_req.key;
        expected_rsp.push_back(apply_request(acc));
        n_accepted++;
      end
      // only move on once the current request is gone (or none was up)
      if (!in_req.valid || in_req.ready) begin
        if (pending_req.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_req.valid <= 1'b1;
          in_req.func <= pending_req[0].func;
          in_req.key <= pending_req[0].key;
          pending_req.pop_front();
        end else begin
          // idle: payload is junk, must be ignored
          in_req.valid <= 1'b0;
          in_req.func <= FUNC_W'($urandom());
          in_req.key <= $urandom();
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random stalls, field compare against oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch($sformatf("response with nothing pending (status %0d)",
                                    out_rsp.status));
        end else begin
          want = expected_rsp.pop_front();
          n_checked++;
          if (out_rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d (response %0d)",
                                      out_rsp.status, want.status, n_checked));
          if (out_rsp.bucket_index !== want.bucket_index)
            report_mismatch($sformatf("bucket_index got %0d expected %0d (response %0d)",
                                      out_rsp.bucket_index, want.bucket_index, n_checked));
          if (out_rsp.removed_count !== want.removed_count)
            report_mismatch($sformatf("removed_count got %0d expected %0d (response %0d)",
                                      out_rsp.removed_count, want.removed_count, n_checked));
          if (want.status <= STAT_FULL) stat_seen[want.status]++;
        end
      end
      out_rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Helpers for the stimulus process
  // --------------------------------------------------------------------------
  task automatic push_req(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
    req_t r;
    r.func = f;
    r.key = k;
    pending_req.push_back(r);
  endtask

  // One APB transfer: setup cycle, access cycle, done when pready is seen.
  task automatic apb_xfer(input bit wr, input logic idx, input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pwdata <= $urandom();
  endtask

  // Write both registers (junk in the unused upper bits), then read back.
  task automatic set_config(input logic [BCNT_W-1:0] bc, input logic sm);
    logic [APB_DATA_W-1:0] rd;
    apb_xfer(1'b1, REG_BUCKET_COUNT, ($urandom() & ~32'h1F) | APB_DATA_W'(bc), rd);
    mdl_bucket_count = bc;
    apb_xfer(1'b1, REG_SET_MODE, ($urandom() & ~32'h1) | APB_DATA_W'(sm), rd);
    mdl_set_mode = sm;
    apb_xfer(1'b0, REG_BUCKET_COUNT, $urandom(), rd);
    if (rd !== APB_DATA_W'(bc))
      report_mismatch($sformatf("bucket_count readback 0x%0h expected 0x%0h", rd, bc));
    apb_xfer(1'b0, REG_SET_MODE, $urandom(), rd);
    if (rd !== APB_DATA_W'(sm))
      report_mismatch($sformatf("set_mode readback 0x%0h expected 0x%0h", rd, sm));
    n_settings++;
  endtask

  // Wait until every request is in and every response is back, then let
  // the pipeline settle.
  task automatic drain();
    @(negedge clk);
    while (pending_req.size() != 0 || in_req.valid || expected_rsp.size() != 0)
      @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // Random request: mostly keys from a small pool so that adds collide,
  // duplicates show up and removes hit.
  task automatic push_random_req();
    int pick;
    logic [FUNC_W-1:0] f;
    logic [KEY_W-1:0] k;
    pick = $urandom_range(99);
    if (pick < 45) f = FUNC_ADD;
    else if (pick < 65) f = FUNC_REMOVE;
    else if (pick < 94) f = FUNC_CONTAINS;
    else f = FUNC_UNDEF;
    if ($urandom_range(99) < 80) k = key_pool[$urandom_range(key_pool.size() - 1)];
    else k = $urandom();
    push_req(f, k);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  logic [BCNT_W-1:0] ph_bc   [RAND_PHASES] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd5, 5'd9};
  logic              ph_sm   [RAND_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  int                ph_src  [RAND_PHASES] = '{0, 52, 0, 8, 0, 52, 0, 8};
  int                ph_sink [RAND_PHASES] = '{0, 0, 52, 8, 0, 0, 52, 8};

  initial begin
    int p;
    int i;
    int pool_n;
    // every input known from time zero
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_req.valid = 1'b0;
    in_req.func = FUNC_ADD;
    in_req.key = '0;
    out_rsp.ready = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    n_errors = 0;
    n_accepted = 0;
    n_checked = 0;
    n_settings = 0;
    for (i = 0; i < 5; i++) stat_seen[i] = 0;
    // golden table after reset: empty, registers at their reset values
    for (i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
    end
    mdl_bucket_count = BUCKET_COUNT_RST;
    mdl_set_mode = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed, multiset mode, 16 buckets ----
    set_config(5'd16, 1'b0);
    push_req(FUNC_CONTAINS, 32'h0000_0000);   // miss on an empty table
    push_req(FUNC_ADD, 32'h0000_0000);
    push_req(FUNC_ADD, 32'h0000_0000);        // repeat allowed here
    push_req(FUNC_CONTAINS, 32'h0000_0000);
    push_req(FUNC_REMOVE, 32'h0000_0000);     // frees both copies
    push_req(FUNC_REMOVE, 32'h0000_0000);     // now absent
    push_req(FUNC_ADD, 32'hFFFF_FFFF);
    push_req(FUNC_CONTAINS, 32'hFFFF_FFFF);
    push_req(FUNC_UNDEF, 32'h8000_0001);      // no-op opcode
    // fill bucket 5, the ninth add finds it full
    for (i = 0; i < DEPTH + 1; i++) push_req(FUNC_ADD, 32'(5 + 16 * i));
    push_req(FUNC_REMOVE, 32'd21);
    push_req(FUNC_CONTAINS, 32'd37);
    drain();

    // ---- directed, set mode ----
    set_config(5'd16, 1'b1);
    push_req(FUNC_ADD, 32'd7);
    push_req(FUNC_ADD, 32'd7);                // rejected as duplicate
    push_req(FUNC_REMOVE, 32'd7);
    drain();

    // ---- random phases over config extremes and idle profiles ----
    for (p = 0; p < RAND_PHASES; p++) begin
      // last two phases draw their settings at random
      if (p >= RAND_PHASES - 2) set_config(BCNT_W'($urandom_range(31)), $urandom_range(1));
      else set_config(ph_bc[p], ph_sm[p]);
      src_idle_pct = ph_src[p];
      sink_stall_pct = ph_sink[p];
      key_pool.delete();
      key_pool.push_back(32'h0000_0000);
      key_pool.push_back(32'hFFFF_FFFF);
      pool_n = 4 + $urandom_range(16);
      for (i = 0; i < pool_n; i++) key_pool.push_back($urandom());
      for (i = 0; i < PHASE_ITEMS; i++) push_random_req();
      drain();
    end

    $display("Ran %0d requests (%0d checked) over %0d register settings and four idle profiles",
             n_accepted, n_checked, n_settings);
    $display("Responses: done %0d, found %0d, not found %0d, duplicate %0d, full %0d",
             stat_seen[STAT_DONE], stat_seen[STAT_FOUND], stat_seen[STAT_NOT_FOUND],
             stat_seen[STAT_DUPLICATE], stat_seen[STAT_FULL]);
    if (n_errors == 0) begin
      $display("PASS chained_hash_set_engine");
    end else begin
      $display("FAIL chained_hash_set_engine");
    end
    $finish;
  end

endmodule
